[src/md5_pkg.sv]
// Shared types, constants and a helper function for the MD5 digest core.
package md5_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [5:0] BLOCK_LAST = 6'd63;
    localparam logic [5:0] ROUND_LAST = 6'd63;
    localparam logic [3:0] EMIT_LAST  = 4'd15;
    localparam logic [7:0] PAD_BYTE   = 8'h80;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;

    localparam logic [31:0] K_TABLE [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] ROT_TABLE [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       is_last;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_qout;

    typedef enum logic [4:0] {
        S_LOAD  = 5'b00001,
        S_ROUND = 5'b00010,
        S_ADD   = 5'b00100,
        S_PAD   = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    function automatic logic [3:0] msg_index(input logic [5:0] rnd);
        logic [3:0] r4;
        logic [3:0] idx;
        r4 = rnd[3:0];
        unique case (rnd[5:4])
            2'd0: idx = r4;
            2'd1: idx = 4'(r4 * 4'd5 + 4'd1);
            2'd2: idx = 4'(r4 * 4'd3 + 4'd5);
            2'd3: idx = 4'(r4 * 4'd7);
        endcase
        return idx;
    endfunction

endpackage

[src/md5_front.sv]
// Input request queue: accepts message items and hands them to the back end.
module md5_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  md5_pkg::t_item   i_item,
    input  logic             i_take,
    output md5_pkg::t_qout   o_q
);

    md5_pkg::t_item                 r_mem [md5_pkg::QUEUE_DEPTH];
    logic [md5_pkg::QPTR_W-1:0]     r_wr_ptr, n_wr_ptr;
    logic [md5_pkg::QPTR_W-1:0]     r_rd_ptr, n_rd_ptr;
    logic [md5_pkg::QCNT_W-1:0]     r_count, n_count;
    logic                           push, pop;

    assign o_stall = (r_count == md5_pkg::QCNT_W'(md5_pkg::QUEUE_DEPTH));
    assign push    = i_valid && !o_stall;
    assign pop     = i_take && (r_count != '0);

    assign o_q.valid = (r_count != '0);
    assign o_q.item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

[src/md5_round.sv]
// One MD5 compression round: mixing function, additions and rotation.
module md5_round (
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    input  logic [31:0] i_c,
    input  logic [31:0] i_d,
    input  logic [5:0]  i_round,
    input  logic [31:0] i_word,
    output logic [31:0] o_b
);

    logic [31:0] f;
    logic [31:0] sum;
    logic [4:0]  s;
    logic [63:0] rot;

    always_comb begin
        unique case (i_round[5:4])
            2'd0: f = (i_b & i_c) | (~i_b & i_d);
            2'd1: f = (i_d & i_b) | (~i_d & i_c);
            2'd2: f = i_b ^ i_c ^ i_d;
            2'd3: f = i_c ^ (i_b | ~i_d);
        endcase
        s   = md5_pkg::ROT_TABLE[{i_round[5:4], i_round[1:0]}];
        sum = i_a + f + md5_pkg::K_TABLE[i_round] + i_word;
        rot = {sum, sum} << s;
        o_b = i_b + rot[63:32];
    end

endmodule

[src/md5_back.sv]
// Back end: block gathering, padding, round sequencing and digest output.
module md5_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  md5_pkg::t_qout   i_q,
    output logic             o_take,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [7:0]       o_digest_byte,
    output logic             o_digest_last
);

    md5_pkg::t_state r_state, n_state;
    md5_pkg::t_state r_after, n_after;
    logic [5:0]      r_round, n_round;
    logic [5:0]      r_pos, n_pos;
    logic [60:0]     r_count, n_count;
    logic [63:0]     r_bits, n_bits;
    logic            r_first, n_first;
    logic            r_len_ok, n_len_ok;
    logic [31:0]     r_a, n_a, r_b, n_b, r_c, n_c, r_d, n_d;
    logic [31:0]     r_chain [4];
    logic [31:0]     n_chain [4];
    logic [3:0]      r_emit_idx, n_emit_idx;
    logic            r_o_valid, n_o_valid;
    logic [7:0]      r_o_byte, n_o_byte;
    logic            r_o_last, n_o_last;
    logic [31:0]     r_block [16];

    logic            wr_en;
    logic [7:0]      wr_byte;
    logic            out_load;
    logic [31:0]     round_b;
    logic [31:0]     emit_word;
    logic [60:0]     count_inc;

    md5_round u_round (
        .i_a     (r_a),
        .i_b     (r_b),
        .i_c     (r_c),
        .i_d     (r_d),
        .i_round (r_round),
        .i_word  (r_block[md5_pkg::msg_index(r_round)]),
        .o_b     (round_b)
    );

    assign emit_word = r_chain[r_emit_idx[3:2]];
    assign count_inc = r_count + 61'd1;

    always_comb begin
        n_state    = r_state;
        n_after    = r_after;
        n_round    = r_round;
        n_pos      = r_pos;
        n_count    = r_count;
        n_bits     = r_bits;
        n_first    = r_first;
        n_len_ok   = r_len_ok;
        n_a        = r_a;
        n_b        = r_b;
        n_c        = r_c;
        n_d        = r_d;
        n_chain    = r_chain;
        n_emit_idx = r_emit_idx;
        n_o_byte   = r_o_byte;
        n_o_last   = r_o_last;
        wr_en      = 1'b0;
        wr_byte    = '0;
        out_load   = 1'b0;
        o_take     = 1'b0;
        unique case (r_state)
            md5_pkg::S_LOAD: begin
                if (i_q.valid) begin
                    o_take = 1'b1;
                    if (i_q.item.has_byte) begin
                        wr_en   = 1'b1;
                        wr_byte = i_q.item.data_byte;
                        n_pos   = r_pos + 6'd1;
                        n_count = count_inc;
                    end
                    if (i_q.item.is_last) begin
                        n_bits   = {(i_q.item.has_byte ? count_inc : r_count), 3'b000};
                        n_first  = 1'b1;
                        n_len_ok = 1'b0;
                    end
                    if (i_q.item.has_byte && r_pos == md5_pkg::BLOCK_LAST) begin
                        n_state = md5_pkg::S_ROUND;
                        n_after = i_q.item.is_last ? md5_pkg::S_PAD : md5_pkg::S_LOAD;
                        n_a     = r_chain[0];
                        n_b     = r_chain[1];
                        n_c     = r_chain[2];
                        n_d     = r_chain[3];
                    end else if (i_q.item.is_last) begin
                        n_state = md5_pkg::S_PAD;
                    end
                end
            end
            md5_pkg::S_PAD: begin
                wr_en = 1'b1;
                if (r_first) begin
                    wr_byte = md5_pkg::PAD_BYTE;
                end else if (r_len_ok && r_pos[5:3] == 3'b111) begin
                    wr_byte = r_bits[{r_pos[2:0], 3'b000} +: 8];
                end
                n_pos   = r_pos + 6'd1;
                n_first = 1'b0;
                if (r_pos == md5_pkg::BLOCK_LAST) begin
                    n_len_ok = 1'b1;
                end else if (r_first) begin
                    n_len_ok = (r_pos[5:3] != 3'b111);
                end
                if (r_pos == md5_pkg::BLOCK_LAST) begin
                    n_state = md5_pkg::S_ROUND;
                    n_after = (!r_first && r_len_ok) ? md5_pkg::S_EMIT : md5_pkg::S_PAD;
                    n_a     = r_chain[0];
                    n_b     = r_chain[1];
                    n_c     = r_chain[2];
                    n_d     = r_chain[3];
                end
            end
            md5_pkg::S_ROUND: begin
                n_a     = r_d;
                n_b     = round_b;
                n_c     = r_b;
                n_d     = r_c;
                n_round = r_round + 6'd1;
                if (r_round == md5_pkg::ROUND_LAST) begin
                    n_state = md5_pkg::S_ADD;
                end
            end
            md5_pkg::S_ADD: begin
                n_chain[0] = r_chain[0] + r_a;
                n_chain[1] = r_chain[1] + r_b;
                n_chain[2] = r_chain[2] + r_c;
                n_chain[3] = r_chain[3] + r_d;
                n_state    = r_after;
            end
            md5_pkg::S_EMIT: begin
                if (!r_o_valid || !i_stall) begin
                    out_load   = 1'b1;
                    n_o_byte   = emit_word[{r_emit_idx[1:0], 3'b000} +: 8];
                    n_o_last   = (r_emit_idx == md5_pkg::EMIT_LAST);
                    n_emit_idx = r_emit_idx + 4'd1;
                    if (r_emit_idx == md5_pkg::EMIT_LAST) begin
                        n_chain[0] = md5_pkg::INIT_A;
                        n_chain[1] = md5_pkg::INIT_B;
                        n_chain[2] = md5_pkg::INIT_C;
                        n_chain[3] = md5_pkg::INIT_D;
                        n_count    = '0;
                        n_pos      = '0;
                        n_state    = md5_pkg::S_LOAD;
                    end
                end
            end
            default: begin
                n_state = md5_pkg::S_LOAD;
            end
        endcase
        n_o_valid = out_load ? 1'b1 : (i_stall ? r_o_valid : 1'b0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= md5_pkg::S_LOAD;
            r_after    <= md5_pkg::S_LOAD;
            r_round    <= '0;
            r_pos      <= '0;
            r_count    <= '0;
            r_first    <= 1'b0;
            r_len_ok   <= 1'b0;
            r_a        <= '0;
            r_b        <= '0;
            r_c        <= '0;
            r_d        <= '0;
            r_chain[0] <= md5_pkg::INIT_A;
            r_chain[1] <= md5_pkg::INIT_B;
            r_chain[2] <= md5_pkg::INIT_C;
            r_chain[3] <= md5_pkg::INIT_D;
            r_emit_idx <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_after    <= n_after;
            r_round    <= n_round;
            r_pos      <= n_pos;
            r_count    <= n_count;
            r_first    <= n_first;
            r_len_ok   <= n_len_ok;
            r_a        <= n_a;
            r_b        <= n_b;
            r_c        <= n_c;
            r_d        <= n_d;
            r_chain    <= n_chain;
            r_emit_idx <= n_emit_idx;
            r_o_valid  <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bits   <= n_bits;
        r_o_byte <= n_o_byte;
        r_o_last <= n_o_last;
        if (wr_en) begin
            r_block[r_pos[5:2]][{r_pos[1:0], 3'b000} +: 8] <= wr_byte;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_digest_byte = r_o_byte;
    assign o_digest_last = r_o_last;

    a_round_only_in_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_round != 6'd0 |-> r_state == md5_pkg::S_ROUND)
        else $error("round counter active outside compression");

    a_round_end_adds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == md5_pkg::S_ROUND && r_round == md5_pkg::ROUND_LAST)
        |=> r_state == md5_pkg::S_ADD)
        else $error("last round not followed by chain update");

    a_emit_only_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emit_idx != 4'd0 |-> r_state == md5_pkg::S_EMIT)
        else $error("digest output interrupted");

    a_digest_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_emit_idx == md5_pkg::EMIT_LAST)
        |=> (r_count == 61'd0 && r_pos == 6'd0 && r_chain[0] == md5_pkg::INIT_A))
        else $error("message state not restarted after digest");

endmodule

[src/md5_message_digest_core.sv]
// Top level of the MD5 digest core: input queue feeding the block engine.
//
// Message bytes enter one request per cycle while o_stall is low into a four-entry queue; the
// engine drains it at one byte per cycle while gathering a 64-byte block. Each full block then
// runs 64 rounds on a single shared round unit and is then added into the chaining words,
// during which up to four more requests are queued before the input stalls. A last request
// adds one padding byte per remaining block position (up to 64, or up to 72 with an extra
// block), one or two compressions, and 16 digest bytes, one per cycle while the output is not
// stalled, low byte of h0 first.
// An item with neither a byte nor the last flag is consumed without effect.
module md5_message_digest_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_has_byte,
    input  logic       i_is_last,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_digest_byte,
    output logic       o_digest_last
);

    md5_pkg::t_item item;
    md5_pkg::t_qout q;
    logic           take;

    assign item.data_byte = i_data_byte;
    assign item.has_byte  = i_has_byte;
    assign item.is_last   = i_is_last;

    md5_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (item),
        .i_take  (take),
        .o_q     (q)
    );

    md5_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q           (q),
        .o_take        (take),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_digest_byte (o_digest_byte),
        .o_digest_last (o_digest_last)
    );

endmodule
